@@ sv/rmps_pkg.sv @@
`default_nettype none
package rmps_pkg;

  // default number of values the store can hold
  localparam int CAPACITY_DEF = 64;

  // cells feeding each partial register of the median select tree
  localparam int SEL_GROUP = 8;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] median_value;
    status_t            status;
    logic [6:0]         stored_count;
  } out_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic               ins_en;
    logic               pop_en;
    logic signed [31:0] value;
  } ctrl_t;

endpackage
`default_nettype wire

@@ sv/rmps_cell.sv @@
`default_nettype none
module rmps_cell import rmps_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctrl_t              ctrl,
  input  wire logic [IW-1:0]      idx,
  input  wire logic signed [31:0] left_value,
  input  wire logic               left_valid,
  input  wire logic               left_ge,
  input  wire logic signed [31:0] right_value,
  input  wire logic               right_valid,
  output logic signed [31:0]      value,
  output logic                    valid,
  output logic                    ge,
  output logic                    sel
);

  logic signed [31:0] value_r, value_nxt;
  logic               valid_r, valid_nxt;

  // this entry stays put on insert: it holds a value not above the new one
  assign ge    = valid_r && !(ctrl.value < value_r);
  assign sel   = (idx == IW'(IDX));
  assign value = value_r;
  assign valid = valid_r;

  // insert: shift right past the new value; pop: close the gap from the right
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.ins_en && !ge) begin
      value_nxt = left_ge ? ctrl.value : left_value;
      valid_nxt = left_valid;
    end else if (ctrl.pop_en && (idx <= IW'(IDX))) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else begin
      value_nxt = value_r;
    end
  end

  // hold occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold entry value
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

@@ sv/running_median_pop_store.sv @@
`default_nettype none
// Sorted multiset of signed 32-bit values kept in a row of compare-and-shift
// cells, one value per cell. A transaction is taken when start is high and
// busy is low; busy then stays high for one cycle while the cells insert or
// close the gap in one pass, and the result, registered at the end of that
// busy cycle, appears on the out_ ports for exactly one cycle with out_valid
// high. A new transaction may be taken in the cycle the result is shown, but
// none while busy is high. The receiver cannot stall: it must take each
// result in the cycle it is presented. A pop returns the lower median (sorted
// index floor((count-1)/2)), read through a registered select tree that
// tracks the current count; a pop on an empty store or an insert into a full
// store leaves the contents unchanged and is flagged in the status.
module running_median_pop_store import rmps_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);
  localparam int GROUPS = (CAPACITY + SEL_GROUP - 1) / SEL_GROUP;

  logic          busy_r;
  logic          out_valid_r;
  out_t          out_r, out_nxt;
  in_t           in_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_dec;
  logic [IW-1:0] idx;
  logic          full, empty;
  ctrl_t         ctrl;

  logic signed [31:0] cell_value [CAPACITY];
  logic               cell_valid [CAPACITY];
  logic               cell_ge    [CAPACITY];
  logic               cell_sel   [CAPACITY];

  logic [31:0] part_r   [GROUPS];
  logic [31:0] part_nxt [GROUPS];
  logic [31:0] median;

  // lower median index of the current contents
  assign count_dec = count_r - CW'(1);
  assign idx       = IW'(count_dec >> 1);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);

  // drive the cells only in the working cycle
  always_comb begin
    ctrl.ins_en = busy_r && (in_r.op == OP_INSERT) && !full;
    ctrl.pop_en = busy_r && (in_r.op == OP_POP) && !empty;
    ctrl.value  = in_r.value;
  end

  // build the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lv, rv;
    logic               lval, lge, rval;
    if (i == 0) begin : g_first
      assign lv   = in_r.value;
      assign lval = 1'b1;
      assign lge  = 1'b1;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign lge  = cell_ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv   = cell_value[i];
      assign rval = 1'b0;
    end else begin : g_inner
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end
    rmps_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .idx         (idx),
      .left_value  (lv),
      .left_valid  (lval),
      .left_ge     (lge),
      .right_value (rv),
      .right_valid (rval),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .ge          (cell_ge[i]),
      .sel         (cell_sel[i])
    );
  end

  // gather the selected entry per group
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < SEL_GROUP; j++) begin
        if ((g * SEL_GROUP + j) < CAPACITY) begin
          if (cell_sel[g * SEL_GROUP + j]) begin
            part_nxt[g] = part_nxt[g] | cell_value[g * SEL_GROUP + j];
          end
        end
      end
    end
  end

  // register the partial selects every cycle
  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      part_r[g] <= part_nxt[g];
    end
  end

  // combine the group results
  always_comb begin
    median = '0;
    for (int g = 0; g < GROUPS; g++) begin
      median = median | part_r[g];
    end
  end

  // settle status, count and returned value
  always_comb begin
    count_nxt = count_r;
    out_nxt   = '0;
    if (in_r.op == OP_INSERT) begin
      if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        count_nxt      = count_r + CW'(1);
        out_nxt.status = ST_INSERTED;
      end
    end else begin
      if (empty) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        count_nxt            = count_dec;
        out_nxt.status       = ST_POPPED;
        out_nxt.median_value = median;
      end
    end
    out_nxt.stored_count = 7'(count_nxt);
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= busy_r;
      if (busy_r) begin
        busy_r  <= 1'b0;
        count_r <= count_nxt;
      end else if (start) begin
        busy_r <= 1'b1;
      end
    end
  end

  // capture the transaction and the result payload
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_data;
    end
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("working cycle did not produce a result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count beyond capacity");

  a_median_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_POPPED) |-> out_data.median_value == '0)
    else $error("non-zero value on a result without a pop");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_POPPED) |->
      count_r == $past(count_r) - CW'(1))
    else $error("pop did not decrement the count");
`endif

endmodule
`default_nettype wire
